// ===== hdl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared types and result codes for the root solver and its cells.
// ----------------------------------------------------------------------------
package qrs_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ONE  = 2'd1;
   localparam logic [1:0] KIND_TWO  = 2'd2;
   localparam logic [1:0] KIND_INF  = 2'd3;

   // Register indexes of the configuration port.
   localparam logic CSR_COEF_TOL = 1'b0;
   localparam logic CSR_DISC_TOL = 1'b1;

   // Per-item control that travels with an item down the chains.
   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic              use_s;
      logic signed [33:0] num;
      logic signed [33:0] den;
   } qrs_ctx_type;

   // Square root partial state: remainder d - s*s and the root so far.
   typedef struct packed {
      logic [65:0] rem;
      logic [32:0] root;
   } qrs_sq_type;

endpackage

// ===== hdl/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// Decides one bit of the integer square root and hands the item on.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell
   import qrs_pkg::*;
#(
   parameter int BIT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  qrs_ctx_type prev_ctx,
   input  qrs_sq_type  prev_sq,
   output qrs_ctx_type ctx,
   output qrs_sq_type  sq
);

   qrs_ctx_type ctx_ff;
   qrs_sq_type  sq_ff;
   qrs_sq_type  sq_in;
   logic [65:0] trial;

   // (s + 2^BIT)^2 - s^2, with the low bits of s still zero.
   always_comb begin
      trial = (66'(prev_sq.root) << (BIT + 1)) | (66'(1) << (2 * BIT));
      sq_in = prev_sq;
      if (prev_sq.rem >= trial) begin
         sq_in.rem  = prev_sq.rem - trial;
         sq_in.root = prev_sq.root | (33'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '0;
         sq_ff  <= '0;
      end else if (adv) begin
         ctx_ff <= prev_ctx;
         sq_ff  <= sq_in;
      end
   end

   assign ctx = ctx_ff;
   assign sq  = sq_ff;

endmodule

// ===== hdl/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step that decides one quotient bit.
// ----------------------------------------------------------------------------
module qrs_div_cell
   import qrs_pkg::*;
#(
   parameter int REM_W = 66,
   parameter int BIT   = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic [REM_W-1:0] prev_rem,
   input  logic [32:0]      prev_den,
   input  logic [31:0]      prev_q,
   input  logic             prev_neg,
   input  logic             prev_big,
   output logic [REM_W-1:0] rem,
   output logic [32:0]      den,
   output logic [31:0]      q,
   output logic             neg,
   output logic             big
);

   logic [REM_W-1:0] rem_ff, rem_in, trial;
   logic [32:0]      den_ff;
   logic [31:0]      q_ff, q_in;
   logic             neg_ff, big_ff;

   // Subtract the shifted divisor when it fits.
   always_comb begin
      trial  = REM_W'(prev_den) << BIT;
      rem_in = prev_rem;
      q_in   = prev_q;
      if (prev_rem >= trial) begin
         rem_in = prev_rem - trial;
         q_in   = prev_q | (32'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         den_ff <= '0;
         q_ff   <= '0;
         neg_ff <= 1'b0;
         big_ff <= 1'b0;
      end else if (adv) begin
         rem_ff <= rem_in;
         den_ff <= prev_den;
         q_ff   <= q_in;
         neg_ff <= prev_neg;
         big_ff <= prev_big;
      end
   end

   assign rem = rem_ff;
   assign den = den_ff;
   assign q   = q_ff;
   assign neg = neg_ff;
   assign big = big_ff;

endmodule

// ===== hdl/quadratic_root_solver_unit.sv =====
// Throughput: one item per cycle; the whole pipeline advances together
// and stalls only while a finished result waits on rsp_tready.
// Latency is set by the 33-cell square root chain and the 32-cell divider chains.
// Reset (synchronous, active high) empties the pipeline and sets both
// tolerance registers to 1.
// ----------------------------------------------------------------------------
// Quadratic root solver
// Returns the real roots of a*x^2 + b*x + c in Q16.16 through a chain of
// square root cells followed by two chains of divider cells.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit
   import qrs_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // coef_square [31:0], coef_linear [63:32], coef_const [95:64]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // root_kind [1:0], root_low [33:2], root_high [65:34], overflow [66]
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [32:0] csr_wdata
);

   localparam int NUM_W = 34 + FRAC_BITS;
   localparam int REM_W = (NUM_W > 65) ? NUM_W + 1 : 66;

   logic adv;

   // Configuration registers.
   logic [16:0] coef_tol_ff;
   logic [32:0] disc_tol_ff;
   logic [16:0] ctol;
   logic [32:0] dtol;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_tol_ff <= 17'd1;
         disc_tol_ff <= 33'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_TOL: coef_tol_ff <= csr_wdata[16:0];
            CSR_DISC_TOL: disc_tol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero tolerance acts as one.
   assign ctol = (coef_tol_ff == '0) ? 17'd1 : coef_tol_ff;
   assign dtol = (disc_tol_ff == '0) ? 33'd1 : disc_tol_ff;

   // Stage 1: products and near-zero tests on the coefficients.
   logic signed [31:0] a, b, c;
   logic [32:0]        mag_a, mag_b, mag_c;
   logic               s1_valid_ff;
   logic signed [31:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic [63:0]        s1_bb_ff;
   logic signed [63:0] s1_ac_ff;
   logic               s1_za_ff, s1_zb_ff, s1_zc_ff;

   assign a = $signed(req_tdata[31:0]);
   assign b = $signed(req_tdata[63:32]);
   assign c = $signed(req_tdata[95:64]);
   assign mag_a = a[31] ? 33'(-$signed({a[31], a})) : {1'b0, a};
   assign mag_b = b[31] ? 33'(-$signed({b[31], b})) : {1'b0, b};
   assign mag_c = c[31] ? 33'(-$signed({c[31], c})) : {1'b0, c};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff  <= a;
         s1_b_ff  <= b;
         s1_c_ff  <= c;
         s1_bb_ff <= 64'(64'(b) * 64'(b));
         s1_ac_ff <= 64'(64'(a) * 64'(c));
         s1_za_ff <= mag_a < {16'd0, ctol};
         s1_zb_ff <= mag_b < {16'd0, ctol};
         s1_zc_ff <= mag_c < {16'd0, ctol};
      end
   end

   // Stage 2: discriminant and classification into the square root chain.
   logic signed [66:0] disc;
   logic [66:0]        disc_mag;
   logic               near;
   qrs_ctx_type        ctx_in;
   qrs_sq_type         sq_in;
   qrs_ctx_type        sq_ctx [0:33];
   qrs_sq_type         sq_val [0:33];
   qrs_ctx_type        ctx_ff;
   qrs_sq_type         sq_ff;

   always_comb begin
      disc     = $signed({3'b000, s1_bb_ff}) - ($signed({{3{s1_ac_ff[63]}}, s1_ac_ff}) <<< 2);
      disc_mag = disc[66] ? 67'(-disc) : 67'(disc);
      near     = disc_mag < {34'd0, dtol};
      ctx_in       = '0;
      ctx_in.valid = s1_valid_ff;
      ctx_in.den   = 34'sd1;
      sq_in        = '0;
      if (s1_za_ff) begin
         if (s1_zb_ff) begin
            ctx_in.kind = s1_zc_ff ? KIND_INF : KIND_NONE;
         end else begin
            ctx_in.kind = KIND_ONE;
            ctx_in.num  = -34'(s1_c_ff);
            ctx_in.den  = 34'(s1_b_ff);
         end
      end else if (near) begin
         ctx_in.kind = KIND_ONE;
         ctx_in.num  = -34'(s1_b_ff);
         ctx_in.den  = 34'(s1_a_ff) <<< 1;
      end else if (!disc[66]) begin
         ctx_in.kind  = KIND_TWO;
         ctx_in.use_s = 1'b1;
         ctx_in.num   = -34'(s1_b_ff);
         ctx_in.den   = 34'(s1_a_ff) <<< 1;
         sq_in.rem    = disc[65:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '0;
         sq_ff  <= '0;
      end else if (adv) begin
         ctx_ff <= ctx_in;
         sq_ff  <= sq_in;
      end
   end

   assign sq_ctx[0] = ctx_ff;
   assign sq_val[0] = sq_ff;

   // Square root chain, most significant bit first.
   for (genvar k = 0; k < 33; k++) begin : g_sqrt
      qrs_sqrt_cell #(.BIT(32 - k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .prev_ctx(sq_ctx[k]),
         .prev_sq (sq_val[k]),
         .ctx     (sq_ctx[k+1]),
         .sq      (sq_val[k+1])
      );
   end

   // Division setup: numerators, magnitudes and the quotient range check.
   qrs_ctx_type        fin;
   logic signed [34:0] num_lo, num_hi, root_s;
   logic [33:0]        nmag_lo, nmag_hi;
   logic [32:0]        dmag;
   logic [REM_W-1:0]   nn_lo, nn_hi, dlim;
   qrs_ctx_type        dctx_ff [0:32];
   logic [REM_W-1:0]   lo_rem [0:32];
   logic [REM_W-1:0]   hi_rem [0:32];
   logic [32:0]        lo_den [0:32];
   logic [32:0]        hi_den [0:32];
   logic [31:0]        lo_q   [0:32];
   logic [31:0]        hi_q   [0:32];
   logic               lo_neg [0:32];
   logic               hi_neg [0:32];
   logic               lo_big [0:32];
   logic               hi_big [0:32];
   logic [REM_W-1:0]   lo_rem_ff, hi_rem_ff;
   logic [32:0]        den_ff;
   logic               lo_neg_ff, hi_neg_ff, lo_big_ff, hi_big_ff;

   assign fin = sq_ctx[33];

   always_comb begin
      root_s  = $signed({2'b00, sq_val[33].root});
      num_lo  = fin.use_s ? 35'(fin.num) - root_s : 35'(fin.num);
      num_hi  = fin.use_s ? 35'(fin.num) + root_s : 35'sd0;
      nmag_lo = num_lo[34] ? 34'(-num_lo) : 34'(num_lo);
      nmag_hi = num_hi[34] ? 34'(-num_hi) : 34'(num_hi);
      dmag    = fin.den[33] ? 33'(-fin.den) : 33'(fin.den);
      nn_lo   = REM_W'(nmag_lo) << FRAC_BITS;
      nn_hi   = REM_W'(nmag_hi) << FRAC_BITS;
      dlim    = REM_W'(dmag) << 32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dctx_ff[0] <= '0;
      end else if (adv) begin
         dctx_ff[0] <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_rem_ff <= nn_lo;
         hi_rem_ff <= nn_hi;
         den_ff    <= dmag;
         lo_neg_ff <= num_lo[34] ^ fin.den[33];
         hi_neg_ff <= num_hi[34] ^ fin.den[33];
         lo_big_ff <= nn_lo >= dlim;
         hi_big_ff <= nn_hi >= dlim;
      end
   end

   assign lo_rem[0] = lo_rem_ff;
   assign hi_rem[0] = hi_rem_ff;
   assign lo_den[0] = den_ff;
   assign hi_den[0] = den_ff;
   assign lo_q[0]   = '0;
   assign hi_q[0]   = '0;
   assign lo_neg[0] = lo_neg_ff;
   assign hi_neg[0] = hi_neg_ff;
   assign lo_big[0] = lo_big_ff;
   assign hi_big[0] = hi_big_ff;

   // Two divider chains side by side, with the item control alongside.
   for (genvar k = 0; k < 32; k++) begin : g_div
      qrs_div_cell #(.REM_W(REM_W), .BIT(31 - k)) u_lo (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .prev_rem(lo_rem[k]),
         .prev_den(lo_den[k]),
         .prev_q  (lo_q[k]),
         .prev_neg(lo_neg[k]),
         .prev_big(lo_big[k]),
         .rem     (lo_rem[k+1]),
         .den     (lo_den[k+1]),
         .q       (lo_q[k+1]),
         .neg     (lo_neg[k+1]),
         .big     (lo_big[k+1])
      );
      qrs_div_cell #(.REM_W(REM_W), .BIT(31 - k)) u_hi (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .prev_rem(hi_rem[k]),
         .prev_den(hi_den[k]),
         .prev_q  (hi_q[k]),
         .prev_neg(hi_neg[k]),
         .prev_big(hi_big[k]),
         .rem     (hi_rem[k+1]),
         .den     (hi_den[k+1]),
         .q       (hi_q[k+1]),
         .neg     (hi_neg[k+1]),
         .big     (hi_big[k+1])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            dctx_ff[k+1] <= '0;
         end else if (adv) begin
            dctx_ff[k+1] <= dctx_ff[k];
         end
      end
   end

   // Final stage: sign, saturation and ordering.
   qrs_ctx_type        last;
   logic signed [31:0] r_lo, r_hi, out_lo, out_hi;
   logic               ov_lo, ov_hi;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_kind_ff;
   logic signed [31:0] rsp_low_ff, rsp_high_ff;
   logic               rsp_ov_ff;

   assign last = dctx_ff[32];

   always_comb begin
      ov_lo = lo_big[32] || (!lo_neg[32] && lo_q[32][31]) ||
              (lo_neg[32] && lo_q[32] > 32'h8000_0000);
      ov_hi = hi_big[32] || (!hi_neg[32] && hi_q[32][31]) ||
              (hi_neg[32] && hi_q[32] > 32'h8000_0000);
      if (ov_lo) begin
         r_lo = lo_neg[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r_lo = lo_neg[32] ? -$signed(lo_q[32]) : $signed(lo_q[32]);
      end
      if (ov_hi) begin
         r_hi = hi_neg[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r_hi = hi_neg[32] ? -$signed(hi_q[32]) : $signed(hi_q[32]);
      end
      out_lo = r_lo;
      out_hi = r_hi;
      if (last.use_s && (r_hi < r_lo)) begin
         out_lo = r_hi;
         out_hi = r_lo;
      end
   end

   assign adv = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_kind_ff <= last.kind;
         rsp_low_ff  <= out_lo;
         rsp_high_ff <= out_hi;
         rsp_ov_ff   <= ov_lo | ov_hi;
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ov_ff, rsp_high_ff, rsp_low_ff, rsp_kind_ff};

   // Two roots always come out ordered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_TWO) |-> (rsp_low_ff <= rsp_high_ff))
      else $error("two roots out of order");

   // No root and infinitely many roots carry zero values and no overflow.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_NONE || rsp_kind_ff == KIND_INF))
      |-> (rsp_low_ff == 0 && rsp_high_ff == 0 && !rsp_ov_ff))
      else $error("rootless result carries data");

   // A single root leaves the upper root at zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_ONE) |-> (rsp_high_ff == 0))
      else $error("single root with nonzero upper root");

endmodule
